// File: rtl/qav_pkg.sv
// Shared types, constants and helper functions for the quaternion angular velocity block.
`default_nettype none

package qav_pkg;

	// Datapath widths
	localparam int DATA_W  = 32;
	localparam int NORM_W  = 65;
	localparam int WIDE_W  = 97;
	localparam int ACC_W   = 98;
	localparam int SACC_W  = 67;
	localparam int MAG_W   = 65;
	localparam int CNT_W   = 3;
	localparam int DIV_STEPS = 33;
	localparam int DIV_CNT_W = 6;

	// Status codes
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_BAD_DT    = 2'd1;
	localparam logic [1:0] STATUS_ZERO_NORM = 2'd2;

	// Frame mode codes
	localparam logic [1:0] MODE_GLOBAL = 2'd0;
	localparam logic [1:0] MODE_BODY   = 2'd1;
	localparam logic [1:0] MODE_PASS   = 2'd2;

	// Register indexes (paddr[2])
	localparam logic REG_FRAME_MODE = 1'b0;
	localparam logic REG_TICKS      = 1'b1;

	localparam logic [DATA_W-1:0] TICKS_RESET = 32'd1000000;
	localparam logic [DATA_W-1:0] ONE_Q30     = 32'h4000_0000;
	localparam logic [NORM_W-1:0] ONE_Q60     = 65'h1_0000_0000_0000_000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NORM,
		ST_DEN,
		ST_PROD,
		ST_MAG,
		ST_NUM,
		ST_DIV,
		ST_DONE
	} state_t;

	// One product of the quaternion multiply: current index, previous index, negate
	typedef struct packed {
		logic [1:0] cur_idx;
		logic [1:0] prv_idx;
		logic       neg;
	} term_t;

	// Magnitude of a signed 32-bit value, exact for the most negative code
	function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] v);
		return v[DATA_W-1] ? (~v + 32'd1) : v;
	endfunction

	// Product terms of current*conj(prev) (global) or conj(prev)*current (body)
	function automatic term_t frame_term(input logic body, input logic [1:0] axis,
			input logic [1:0] idx);
		term_t t;
		case ({body, axis, idx})
			5'b0_00_00: t = '{2'd0, 2'd1, 1'b1};
			5'b0_00_01: t = '{2'd1, 2'd0, 1'b0};
			5'b0_00_10: t = '{2'd2, 2'd3, 1'b1};
			5'b0_00_11: t = '{2'd3, 2'd2, 1'b0};
			5'b0_01_00: t = '{2'd0, 2'd2, 1'b1};
			5'b0_01_01: t = '{2'd1, 2'd3, 1'b0};
			5'b0_01_10: t = '{2'd2, 2'd0, 1'b0};
			5'b0_01_11: t = '{2'd3, 2'd1, 1'b1};
			5'b0_10_00: t = '{2'd0, 2'd3, 1'b1};
			5'b0_10_01: t = '{2'd1, 2'd2, 1'b1};
			5'b0_10_10: t = '{2'd2, 2'd1, 1'b0};
			5'b0_10_11: t = '{2'd3, 2'd0, 1'b0};
			5'b1_00_00: t = '{2'd1, 2'd0, 1'b0};
			5'b1_00_01: t = '{2'd0, 2'd1, 1'b1};
			5'b1_00_10: t = '{2'd3, 2'd2, 1'b1};
			5'b1_00_11: t = '{2'd2, 2'd3, 1'b0};
			5'b1_01_00: t = '{2'd2, 2'd0, 1'b0};
			5'b1_01_01: t = '{2'd3, 2'd1, 1'b0};
			5'b1_01_10: t = '{2'd0, 2'd2, 1'b1};
			5'b1_01_11: t = '{2'd1, 2'd3, 1'b1};
			5'b1_10_00: t = '{2'd3, 2'd0, 1'b0};
			5'b1_10_01: t = '{2'd2, 2'd1, 1'b1};
			5'b1_10_10: t = '{2'd1, 2'd2, 1'b0};
			5'b1_10_11: t = '{2'd0, 2'd3, 1'b1};
			default:    t = '{2'd0, 2'd0, 1'b0};
		endcase
		return t;
	endfunction

endpackage

`default_nettype wire

// File: rtl/qav_div.sv
// Restoring divider with round-half-up and saturation to a signed Q16.16 rate.
`default_nettype none

module qav_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [qav_pkg::WIDE_W-1:0]  num,
	input  logic [qav_pkg::WIDE_W-1:0]  den,
	input  logic                        neg,
	output logic                        done,
	output logic [qav_pkg::DATA_W-1:0]  rate
);

	logic                          busy_q;
	logic                          done_q;
	logic [qav_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [qav_pkg::WIDE_W-1:0]    rem_q;
	logic [qav_pkg::DIV_STEPS-1:0] low_q;
	logic [qav_pkg::DIV_STEPS-1:0] quo_q;
	logic                          sat_q;
	logic [qav_pkg::DATA_W-1:0]    rate_q;

	logic [qav_pkg::ACC_W-1:0]     rem_sh;
	logic [qav_pkg::ACC_W-1:0]     den_x;
	logic [qav_pkg::ACC_W-1:0]     diff;
	logic                          ge;
	logic                          fin;
	logic                          round_up;
	logic [qav_pkg::DIV_STEPS:0]   qr;
	logic                          big;
	logic [qav_pkg::DATA_W-1:0]    res;

	// One quotient bit per cycle
	always_comb begin
		den_x    = {1'b0, den};
		rem_sh   = {rem_q, low_q[qav_pkg::DIV_STEPS-1]};
		ge       = rem_sh >= den_x;
		diff     = rem_sh - den_x;
		fin      = busy_q && (cnt_q == '0);
		round_up = {rem_q, 1'b0} >= den_x;
		qr       = {1'b0, quo_q} + (qav_pkg::DIV_STEPS+1)'(round_up);
		big      = sat_q || (qr >= 34'h0_8000_0000);
		if (neg) begin
			res = big ? 32'h8000_0000 : (~qr[31:0] + 32'd1);
		end else begin
			res = big ? 32'h7FFF_FFFF : qr[31:0];
		end
	end

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= qav_pkg::DIV_CNT_W'(qav_pkg::DIV_STEPS);
			end else if (fin) begin
				busy_q <= 1'b0;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Remainder, quotient and result
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {16'b0, num[qav_pkg::WIDE_W-1:16]};
			sat_q <= {16'b0, num[qav_pkg::WIDE_W-1:16]} >= den;
			low_q <= {num[15:0], 17'b0};
			quo_q <= '0;
		end else if (busy_q && !fin) begin
			rem_q <= ge ? diff[qav_pkg::WIDE_W-1:0] : rem_sh[qav_pkg::WIDE_W-1:0];
			quo_q <= {quo_q[qav_pkg::DIV_STEPS-2:0], ge};
			low_q <= {low_q[qav_pkg::DIV_STEPS-2:0], 1'b0};
		end
		if (fin) begin
			rate_q <= res;
		end
	end

	assign done = done_q;
	assign rate = rate_q;

endmodule

`default_nettype wire

// File: rtl/quaternion_angular_velocity_top.sv
// Top level: angular velocity from successive timestamped orientation quaternions.
//
//   channel  direction  handshake            payload
//   cfg      in/out     psel/penable/pready  paddr, pwdata, prdata
//   in       in         in_valid/in_stall    series_start, sample_time, quat_w..quat_z
//   out      out        out_valid/out_stall  out_time, rate_x..rate_z, status
//
// One sample at a time on a shared 32x32 multiplier and a bit-serial divider.
// First sample of a series: stored only. Faulted sample: straight to the output wait.
// Global/body: norm, den, then per axis prod, mag, num, div; pass skips norm. Plus output wait.
// Reset sets the registers to defaults, clears the previous sample and the control state.
// in_stall is high while a sample is in work; out_stall only holds the final transfer.
`default_nettype none

module quaternion_angular_velocity_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [2:0]                 paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       series_start,
	input  logic [31:0]                sample_time,
	input  logic signed [31:0]         quat_w,
	input  logic signed [31:0]         quat_x,
	input  logic signed [31:0]         quat_y,
	input  logic signed [31:0]         quat_z,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [31:0]                out_time,
	output logic signed [31:0]         rate_x,
	output logic signed [31:0]         rate_y,
	output logic signed [31:0]         rate_z,
	output logic [1:0]                 status
);

	qav_pkg::state_t state_q, nxt_state;

	logic [1:0]                   mode_q;
	logic [qav_pkg::DATA_W-1:0]   tps_q;
	logic [qav_pkg::DATA_W-1:0]   prev_q [4];
	logic [qav_pkg::DATA_W-1:0]   prev_time_q;
	logic                         have_prev_q;
	logic [qav_pkg::DATA_W-1:0]   cur_q [4];
	logic [qav_pkg::DATA_W-1:0]   old_q [4];
	logic [qav_pkg::DATA_W-1:0]   time_q;
	logic [qav_pkg::DATA_W-1:0]   dt_q;
	logic [1:0]                   status_q;
	logic [qav_pkg::NORM_W-1:0]   norm_q;
	logic [qav_pkg::WIDE_W-1:0]   den_q;
	logic [qav_pkg::SACC_W-1:0]   sacc_q;
	logic [qav_pkg::MAG_W-1:0]    mag_q;
	logic                         neg_q;
	logic [qav_pkg::WIDE_W-1:0]   num_q;
	logic [qav_pkg::DATA_W-1:0]   rate_q [3];
	logic [qav_pkg::CNT_W-1:0]    cnt_q;
	logic [1:0]                   axis_q;
	logic [qav_pkg::ACC_W-1:0]    acc_q;
	logic [63:0]                  prod_s1;
	logic                         pneg_s1;
	logic [1:0]                   psh_s1;
	logic                         pvld_s1;
	logic                         out_valid_q;
	logic [qav_pkg::DATA_W-1:0]   out_time_q;
	logic [qav_pkg::DATA_W-1:0]   out_rate_q [3];
	logic [1:0]                   out_status_q;

	logic [qav_pkg::DATA_W-1:0]   comp_in [4];
	logic                         cfg_wr;
	logic                         in_fire;
	logic                         first;
	logic                         relative;
	logic                         body;
	logic                         zero_prev;
	logic                         dt_pos;
	logic [1:0]                   fault;
	logic [qav_pkg::CNT_W-1:0]    op_count;
	logic                         phase_end;
	logic                         mult_state;
	logic                         issue;
	qav_pkg::term_t               tm;
	logic [1:0]                   ci;
	logic [1:0]                   pi;
	logic [qav_pkg::DATA_W-1:0]   mul_a;
	logic [qav_pkg::DATA_W-1:0]   mul_b;
	logic                         mul_neg;
	logic [1:0]                   mul_sh;
	logic [qav_pkg::ACC_W-1:0]    ext;
	logic [qav_pkg::ACC_W-1:0]    term;
	logic [qav_pkg::ACC_W-1:0]    acc_sum;
	logic [qav_pkg::SACC_W-1:0]   sacc_abs;
	logic                         div_start;
	logic                         div_done;
	logic [qav_pkg::DATA_W-1:0]   div_rate;
	logic                         out_load;

	// Decode the incoming transfer and the fault checks
	always_comb begin
		comp_in[0] = quat_w;
		comp_in[1] = quat_x;
		comp_in[2] = quat_y;
		comp_in[3] = quat_z;
		cfg_wr     = psel && penable && pwrite;
		in_fire    = in_valid && !in_stall;
		first      = series_start || !have_prev_q;
		relative   = !mode_q[1];
		body       = mode_q == qav_pkg::MODE_BODY;
		zero_prev  = (prev_q[0] == '0) && (prev_q[1] == '0) &&
			(prev_q[2] == '0) && (prev_q[3] == '0);
		dt_pos     = sample_time > prev_time_q;
		if (!dt_pos) begin
			fault = qav_pkg::STATUS_BAD_DT;
		end else if (relative && zero_prev) begin
			fault = qav_pkg::STATUS_ZERO_NORM;
		end else begin
			fault = qav_pkg::STATUS_OK;
		end
	end

	// Operations per phase
	always_comb begin
		unique case (state_q)
			qav_pkg::ST_NORM: op_count = 3'd4;
			qav_pkg::ST_DEN:  op_count = 3'd3;
			qav_pkg::ST_PROD: op_count = relative ? 3'd4 : 3'd1;
			qav_pkg::ST_NUM:  op_count = 3'd3;
			qav_pkg::ST_DIV:  op_count = 3'd1;
			default:          op_count = 3'd0;
		endcase
		phase_end  = cnt_q == op_count;
		mult_state = (state_q == qav_pkg::ST_NORM) || (state_q == qav_pkg::ST_DEN) ||
			(state_q == qav_pkg::ST_PROD) || (state_q == qav_pkg::ST_NUM);
	end

	// Next state
	always_comb begin
		nxt_state = state_q;
		unique case (state_q)
			qav_pkg::ST_IDLE: begin
				if (in_fire && !first) begin
					if (fault != qav_pkg::STATUS_OK) begin
						nxt_state = qav_pkg::ST_DONE;
					end else if (relative) begin
						nxt_state = qav_pkg::ST_NORM;
					end else begin
						nxt_state = qav_pkg::ST_DEN;
					end
				end
			end
			qav_pkg::ST_NORM: if (phase_end) nxt_state = qav_pkg::ST_DEN;
			qav_pkg::ST_DEN:  if (phase_end) nxt_state = qav_pkg::ST_PROD;
			qav_pkg::ST_PROD: if (phase_end) nxt_state = qav_pkg::ST_MAG;
			qav_pkg::ST_MAG:  nxt_state = qav_pkg::ST_NUM;
			qav_pkg::ST_NUM:  if (phase_end) nxt_state = qav_pkg::ST_DIV;
			qav_pkg::ST_DIV: begin
				if (div_done) begin
					nxt_state = (axis_q == 2'd2) ? qav_pkg::ST_DONE : qav_pkg::ST_PROD;
				end
			end
			qav_pkg::ST_DONE: if (!out_valid_q || !out_stall) nxt_state = qav_pkg::ST_IDLE;
			default:          nxt_state = qav_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: handshake, multiplier operands, divider start
	always_comb begin
		in_stall  = state_q != qav_pkg::ST_IDLE;
		issue     = mult_state && !phase_end;
		div_start = (state_q == qav_pkg::ST_DIV) && (cnt_q == '0);
		out_load  = (state_q == qav_pkg::ST_DONE) && (!out_valid_q || !out_stall);
		tm        = qav_pkg::frame_term(body, axis_q, cnt_q[1:0]);
		ci        = relative ? tm.cur_idx : (axis_q + 2'd1);
		pi        = (state_q == qav_pkg::ST_NORM) ? cnt_q[1:0] : tm.prv_idx;
		mul_a     = '0;
		mul_b     = '0;
		mul_neg   = 1'b0;
		mul_sh    = 2'd0;
		unique case (state_q)
			qav_pkg::ST_NORM: begin
				mul_a = qav_pkg::mag32(old_q[pi]);
				mul_b = mul_a;
			end
			qav_pkg::ST_DEN: begin
				unique case (cnt_q[1:0])
					2'd0:    mul_a = norm_q[31:0];
					2'd1:    mul_a = norm_q[63:32];
					default: mul_a = {31'b0, norm_q[64]};
				endcase
				mul_b  = dt_q;
				mul_sh = cnt_q[1:0];
			end
			qav_pkg::ST_PROD: begin
				mul_a = qav_pkg::mag32(cur_q[ci]);
				if (relative) begin
					mul_b   = qav_pkg::mag32(old_q[pi]);
					mul_neg = tm.neg ^ cur_q[ci][31] ^ old_q[pi][31];
				end else begin
					mul_b   = qav_pkg::ONE_Q30;
					mul_neg = cur_q[ci][31];
				end
			end
			qav_pkg::ST_NUM: begin
				unique case (cnt_q[1:0])
					2'd0:    mul_a = mag_q[31:0];
					2'd1:    mul_a = mag_q[63:32];
					default: mul_a = {31'b0, mag_q[64]};
				endcase
				mul_b  = tps_q;
				mul_sh = cnt_q[1:0];
			end
			default: begin
				mul_a = '0;
			end
		endcase
	end

	// Accumulate the registered product at its word offset
	always_comb begin
		ext      = qav_pkg::ACC_W'(prod_s1) << {psh_s1, 5'b0};
		term     = pvld_s1 ? (pneg_s1 ? (~ext + 1'b1) : ext) : '0;
		acc_sum  = acc_q + term;
		sacc_abs = sacc_q[qav_pkg::SACC_W-1] ? (~sacc_q + 1'b1) : sacc_q;
	end

	// Configuration registers
	assign pready = 1'b1;
	assign prdata = (paddr[2] == qav_pkg::REG_TICKS) ? tps_q : {30'b0, mode_q};

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= qav_pkg::ST_IDLE;
			mode_q      <= qav_pkg::MODE_GLOBAL;
			tps_q       <= qav_pkg::TICKS_RESET;
			prev_q      <= '{default: '0};
			prev_time_q <= '0;
			have_prev_q <= 1'b0;
			cnt_q       <= '0;
			axis_q      <= '0;
			acc_q       <= '0;
			pvld_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= nxt_state;
			if (cfg_wr) begin
				if (paddr[2] == qav_pkg::REG_TICKS) begin
					tps_q <= pwdata;
				end else begin
					mode_q <= pwdata[1:0];
				end
			end
			if (in_fire) begin
				prev_q      <= comp_in;
				prev_time_q <= sample_time;
				have_prev_q <= 1'b1;
				axis_q      <= '0;
			end else if ((state_q == qav_pkg::ST_DIV) && div_done) begin
				axis_q <= axis_q + 2'd1;
			end
			if (state_q != nxt_state) begin
				cnt_q <= '0;
			end else if (!phase_end) begin
				cnt_q <= cnt_q + 1'b1;
			end
			pvld_s1 <= issue;
			acc_q   <= (mult_state && phase_end) ? '0 : acc_sum;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		prod_s1 <= 64'(mul_a) * 64'(mul_b);
		pneg_s1 <= mul_neg;
		psh_s1  <= mul_sh;
		if (in_fire) begin
			cur_q    <= comp_in;
			old_q    <= prev_q;
			time_q   <= sample_time;
			dt_q     <= sample_time - prev_time_q;
			status_q <= fault;
			norm_q   <= qav_pkg::ONE_Q60;
			rate_q   <= '{default: '0};
		end
		if (phase_end) begin
			unique case (state_q)
				qav_pkg::ST_NORM: norm_q <= acc_sum[qav_pkg::NORM_W-1:0];
				qav_pkg::ST_DEN:  den_q  <= acc_sum[qav_pkg::WIDE_W-1:0];
				qav_pkg::ST_PROD: sacc_q <= acc_sum[qav_pkg::SACC_W-1:0];
				qav_pkg::ST_NUM:  num_q  <= acc_sum[qav_pkg::WIDE_W-1:0];
				default:          ;
			endcase
		end
		if (state_q == qav_pkg::ST_MAG) begin
			mag_q <= sacc_abs[qav_pkg::MAG_W-1:0];
			neg_q <= sacc_q[qav_pkg::SACC_W-1];
		end
		if ((state_q == qav_pkg::ST_DIV) && div_done) begin
			rate_q[axis_q] <= div_rate;
		end
		if (out_load) begin
			out_time_q   <= time_q;
			out_rate_q   <= rate_q;
			out_status_q <= status_q;
		end
	end

	// Shared divider for the three rates
	qav_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (den_q),
		.neg    (neg_q),
		.done   (div_done),
		.rate   (div_rate)
	);

	assign out_valid = out_valid_q;
	assign out_time  = out_time_q;
	assign rate_x    = out_rate_q[0];
	assign rate_y    = out_rate_q[1];
	assign rate_z    = out_rate_q[2];
	assign status    = out_status_q;

endmodule

`default_nettype wire
